/* hw/rtl/tsrd_pkg.sv */
package tsrd_pkg;

  localparam int unsigned TIME_W     = 64;
  localparam int unsigned INTERVAL_W = 63;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 63'd100000000;
  localparam logic [TIME_W-1:0]     TIME_MAX       = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    SEL_NONE     = 2'd0,
    SEL_CURRENT  = 2'd1,
    SEL_PREVIOUS = 2'd2
  } sel_e;

  typedef struct packed {
    logic              command;
    logic [TIME_W-1:0] sample_time;
  } item_t;

  typedef struct packed {
    sel_e              selection;
    logic [TIME_W-1:0] selected_time;
  } result_t;

  typedef struct packed {
    logic              have_history;
    logic [TIME_W-1:0] previous_time;
    logic [TIME_W-1:0] next_target;
    logic              have_selected;
    logic [TIME_W-1:0] last_selected_time;
  } state_t;

  // a is non-negative, so the true sum fits 64 bits unsigned; top bit set = overflow
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0]     a,
                                                input logic [INTERVAL_W-1:0] b);
    logic [TIME_W-1:0] s;
    s = a + {1'b0, b};
    return s[TIME_W-1] ? TIME_MAX : s;
  endfunction

endpackage

/* hw/rtl/tsrd_select.sv */
module tsrd_select import tsrd_pkg::*; (
  input  item_t                 item_i,
  input  state_t                state_i,
  input  logic [INTERVAL_W-1:0] interval_i,
  output state_t                state_o,
  output result_t               result_o
);

  logic [TIME_W-1:0] t, nt, prev;
  logic [TIME_W-1:0] t_plus, nt_plus, diff_cur, diff_prev, nt_adv, chosen;
  logic              overshoot, prev_nearer;
  sel_e              sel;

  assign t    = item_i.sample_time;
  assign nt   = state_i.next_target;
  assign prev = state_i.previous_time;

  assign t_plus    = sat_add(t, interval_i);
  assign nt_plus   = sat_add(nt, interval_i);
  assign diff_cur  = t - nt;
  assign diff_prev = nt - prev;

  // overshoot by a full interval restarts the target from this sample
  assign overshoot   = diff_cur >= {1'b0, interval_i};
  assign prev_nearer = $signed(diff_prev) < $signed(diff_cur);
  // advanced target must stay ahead of the current sample
  assign nt_adv = ($signed(nt_plus) <= $signed(t)) ? t_plus : nt_plus;

  always_comb begin
    if (overshoot || !prev_nearer) begin
      sel    = SEL_CURRENT;
      chosen = t;
    end else begin
      sel    = SEL_PREVIOUS;
      chosen = prev;
    end
  end

  always_comb begin
    state_o                = state_i;
    result_o.selection     = SEL_NONE;
    result_o.selected_time = '0;
    priority if (item_i.command) begin
      state_o = '0;
    end else if (!($signed(t) > 0) || (interval_i == '0)) begin
      state_o = state_i;
    end else if (!state_i.have_history) begin
      state_o.have_history       = 1'b1;
      state_o.previous_time      = t;
      state_o.next_target        = t_plus;
      state_o.have_selected      = 1'b1;
      state_o.last_selected_time = t;
      result_o.selection         = SEL_CURRENT;
      result_o.selected_time     = t;
    end else if ($signed(t) <= $signed(prev)) begin
      state_o = state_i;
    end else begin
      state_o.previous_time = t;
      if ($signed(t) >= $signed(nt)) begin
        state_o.next_target = overshoot ? t_plus : nt_adv;
        if (!(state_i.have_selected &&
              ($signed(chosen) <= $signed(state_i.last_selected_time)))) begin
          state_o.have_selected      = 1'b1;
          state_o.last_selected_time = chosen;
          result_o.selection         = sel;
          result_o.selected_time     = chosen;
        end
      end
    end
  end

endmodule

/* hw/rtl/timestamp_rate_decimator_unit.sv */
// Timestamp rate decimator: one result per sample or clear command.
// The item is held in the input register, and its decision is stored in the result
// register that drives the outputs.
// Throughput: one item per cycle unless a held result stalls the input; the decision is
// one pass of 64-bit adds and compares between the input register and the result register.
// Reset (rst_ni low, asynchronous): selector state cleared, both stages empty,
// target_interval back to 100000000 ns.
module timestamp_rate_decimator_unit import tsrd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // sample channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  command_i,
  input  logic [TIME_W-1:0]     sample_time_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            selection_o,
  output logic [TIME_W-1:0]     selected_time_o,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [INTERVAL_W-1:0] cfg_target_interval_i
);

  logic                  in_valid_q, in_valid_d;
  item_t                 item_q;
  logic                  out_valid_q, out_valid_d;
  result_t               res_q, res_d;
  state_t                state_q, state_d;
  logic [INTERVAL_W-1:0] interval_q;
  logic                  in_xfer, advance;

  // item in the input register moves on whenever the result register is free
  // or being emptied this cycle
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign in_valid_d = in_xfer || (in_valid_q && !advance);

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  tsrd_select u_select (
    .item_i     (item_q),
    .state_i    (state_q),
    .interval_i (interval_q),
    .state_o    (state_d),
    .result_o   (res_d)
  );

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
      interval_q  <= INTERVAL_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
      if (cfg_valid_i) begin
        interval_q <= cfg_target_interval_i;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.command     <= command_i;
      item_q.sample_time <= sample_time_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign selection_o     = res_q.selection;
  assign selected_time_o = res_q.selected_time;

  // stall only ever comes from a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  // a result with no choice carries a zero time
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (selection_o == SEL_NONE)) |-> (selected_time_o == '0))
    else $error("selection none with non-zero time");

  // any chosen time is strictly positive
  a_chosen_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (selection_o != SEL_NONE)) |-> ($signed(selected_time_o) > 0))
    else $error("chosen time not positive");

  // an item facing a free result register reaches it in the next cycle
  a_item_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_valid_o) |=> out_valid_o)
    else $error("item not moved to free result register");

endmodule

/* tb/sv/tb_timestamp_rate_decimator_unit.sv */
module tb_timestamp_rate_decimator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tsrd_pkg::*;

  // Long receiver hold for the back-pressure phase, and the watchdog limit on
  // cycles with no transfer on any channel (several times the longest hold).
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;

  logic                  clk_i                 = 1'b0;
  logic                  rst_ni                = 1'b0;
  logic                  in_valid_i            = 1'b0;
  logic                  in_stall_o;
  logic                  command_i             = 1'b0;
  logic [TIME_W-1:0]     sample_time_i         = '0;
  logic                  out_valid_o;
  logic                  out_stall_i           = 1'b0;
  logic [1:0]            selection_o;
  logic [TIME_W-1:0]     selected_time_o;
  logic                  cfg_valid_i           = 1'b0;
  logic                  cfg_ready_o;
  logic [INTERVAL_W-1:0] cfg_target_interval_i = '0;

  timestamp_rate_decimator_unit dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .command_i             (command_i),
    .sample_time_i         (sample_time_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .selection_o           (selection_o),
    .selected_time_o       (selected_time_o),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_target_interval_i (cfg_target_interval_i)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Selector model: own copy of the interval register and the decimator state.
  // ---------------------------------------------------------------------------
  logic [INTERVAL_W-1:0] interval_ns = INTERVAL_RESET;
  logic                  has_sample  = 1'b0;
  logic signed [63:0]    last_time   = '0;
  logic signed [63:0]    target_time = '0;
  logic                  has_pick    = 1'b0;
  logic signed [63:0]    last_pick   = '0;

  item_t   sample_q[$];  // items waiting for the driver
  result_t decision_q[$]; // predicted decisions, oldest first
  item_t   offer;
  int      fail_count = 0;

  // Idling knobs, written only by the stimulus process
  int gap_max    = 1;
  int stall_mode = 1;
  bit hold_req   = 1'b0;

  // Target sums clamp at the largest positive time; a is never negative here.
  function automatic logic signed [63:0] add_sat(input logic signed [63:0]    a,
                                                 input logic [INTERVAL_W-1:0] b);
    logic [64:0] sum;
    sum = {1'b0, a} + {2'b0, b};
    return (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[63:0];
  endfunction

  // One step of the selector: updates the model state, returns the decision.
  function automatic result_t decimate(input logic cmd, input logic signed [63:0] t);
    result_t            r;
    logic signed [63:0] earlier;
    logic signed [63:0] chosen;
    logic signed [63:0] d_prev;
    logic signed [63:0] d_cur;
    sel_e               which;
    r.selection     = SEL_NONE;
    r.selected_time = '0;
    if (cmd) begin
      has_sample  = 1'b0;
      last_time   = '0;
      target_time = '0;
      has_pick    = 1'b0;
      last_pick   = '0;
      return r;
    end
    if (t <= 0 || interval_ns == 0) return r;
    // first valid sample is always taken and arms the target
    if (!has_sample) begin
      has_sample      = 1'b1;
      last_time       = t;
      target_time     = add_sat(t, interval_ns);
      has_pick        = 1'b1;
      last_pick       = t;
      r.selection     = SEL_CURRENT;
      r.selected_time = t;
      return r;
    end
    if (t <= last_time) return r;
    earlier   = last_time;
    last_time = t;
    if (t < target_time) return r;
    if ($unsigned(t - target_time) >= {1'b0, interval_ns}) begin
      // overshot by a whole interval: restart the target from this sample
      target_time = add_sat(t, interval_ns);
      which       = SEL_CURRENT;
      chosen      = t;
    end else begin
      d_prev = target_time - earlier;
      d_cur  = t - target_time;
      // a tie goes to the current sample
      if (d_prev < d_cur) begin
        which  = SEL_PREVIOUS;
        chosen = earlier;
      end else begin
        which  = SEL_CURRENT;
        chosen = t;
      end
      target_time = add_sat(target_time, interval_ns);
      if (target_time <= t) target_time = add_sat(t, interval_ns);
    end
    if (has_pick && chosen <= last_pick) return r;
    has_pick        = 1'b1;
    last_pick       = chosen;
    r.selection     = which;
    r.selected_time = chosen;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sample driver: bursts of random length, random gaps between them.
  // The model is stepped at the edge where the transfer happens.
  // ---------------------------------------------------------------------------
  int burst_cnt = 1;
  int gap_cnt   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        decision_q.push_back(decimate(command_i, sample_time_i));
      if (!in_valid_i || !in_stall_o) begin
        if (gap_cnt != 0 || sample_q.size() == 0) begin
          in_valid_i <= 1'b0;
          if (gap_cnt != 0) gap_cnt <= gap_cnt - 1;
        end else begin
          offer = sample_q.pop_front();
          in_valid_i    <= 1'b1;
          command_i     <= offer.command;
          sample_time_i <= offer.sample_time;
          if (burst_cnt <= 1) begin
            burst_cnt <= $urandom_range(16, 1);
            gap_cnt   <= $urandom_range(gap_max, 0);
          end else begin
            burst_cnt <= burst_cnt - 1;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor and receiver stall pattern.
  // Mode 0: never stalls; 1: random scattered stalls; 2: runs of stall/go.
  // One long hold when requested, counted here.
  // ---------------------------------------------------------------------------
  int      hold_cnt  = 0;
  bit      hold_done = 1'b0;
  int      run_left  = 0;
  bit      run_stall = 1'b0;
  result_t want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (decision_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result sel=%0d time=%0d", $time, selection_o,
                     $signed(selected_time_o));
          fail_count <= fail_count + 1;
        end else begin
          want = decision_q.pop_front();
          if (selection_o !== want.selection || selected_time_o !== want.selected_time) begin
            if (fail_count < 10)
              $display("%0t: mismatch sel exp %0d got %0d, time exp %0d got %0d", $time,
                       want.selection, selection_o, $signed(want.selected_time),
                       $signed(selected_time_o));
            fail_count <= fail_count + 1;
          end
        end
      end
      if (hold_cnt != 0) begin
        out_stall_i <= 1'b1;
        hold_cnt    <= hold_cnt - 1;
      end else if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        hold_cnt    <= HOLD_CYCLES;
        hold_done   <= 1'b1;
      end else begin
        case (stall_mode)
          1: out_stall_i <= ($urandom_range(3) == 0);
          2: begin
            if (run_left == 0) begin
              run_left  <= $urandom_range(8, 1);
              run_stall <= ~run_stall;
              out_stall_i <= ~run_stall;
            end else begin
              run_left    <= run_left - 1;
              out_stall_i <= run_stall;
            end
          end
          default: out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any transfer on any channel restarts the count.
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("timestamp_rate_decimator_unit test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // uniform-ish in [0, n]; n stays below 2**63
  function automatic logic [63:0] rand_upto(input logic [63:0] n);
    return rand64() % (n + 1);
  endfunction

  task automatic push_sample(input logic [63:0] t);
    sample_q.push_back('{command: 1'b0, sample_time: t});
  endtask

  task automatic push_clear(input logic [63:0] t);
    sample_q.push_back('{command: 1'b1, sample_time: t});
  endtask

  // Block idle: nothing queued, nothing offered, every decision returned.
  // One result per item, so a short margin is plenty.
  task automatic settle();
    do @(posedge clk_i);
    while (sample_q.size() != 0 || in_valid_i || decision_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_interval(input logic [INTERVAL_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i           <= 1'b1;
    cfg_target_interval_i <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    interval_ns = value;
  endtask

  // Mostly rising time sequences stepped around the interval, with some noise,
  // backward steps, repeats and clears mixed in.
  task automatic run_phase(input logic [INTERVAL_W-1:0] iv, input int gaps,
                           input int stalls, input bit squeeze, input int count);
    logic [65:0] cur;
    logic [65:0] step;
    logic [63:0] scale;
    int          pick;
    settle();
    write_interval(iv);
    gap_max    = gaps;
    stall_mode = stalls;
    if (squeeze) hold_req = 1'b1;
    scale = (iv == 0) ? 64'd1000 : {1'b0, iv};
    cur   = '0;
    push_clear(rand64());
    for (int k = 1; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 4 || cur == TIME_MAX) begin
        push_clear(rand64());
        cur = '0;
      end else if (pick < 10) begin
        push_sample(rand64());
      end else if (pick < 14 && cur != 0) begin
        push_sample(cur[63:0] - rand_upto(scale >> 3));
      end else begin
        if (cur == 0) begin
          cur = 1 + rand_upto(scale >> 1);
        end else begin
          case ($urandom_range(3))
            0:       step = 1 + rand_upto(scale >> 2);
            1:       step = (scale >> 1) + rand_upto(scale);
            2:       step = scale - 1 + $urandom_range(2);
            default: step = 2 * scale + rand_upto(scale);
          endcase
          cur = cur + step;
          if (cur > TIME_MAX) cur = TIME_MAX;
        end
        push_sample(cur[63:0]);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed pass at the reset interval of 100 ms
    gap_max    = 2;
    stall_mode = 1;
    push_sample(64'd0);                       // zero time
    push_sample(64'hFFFF_FFFF_FFFF_FFFF);     // -1
    push_sample(64'h8000_0000_0000_0000);     // most negative
    push_sample(64'd1000);                    // first sample, always taken
    push_sample(64'd1000);                    // repeat of previous
    push_sample(64'd500);                     // going backwards
    push_sample(64'd50_001_000);              // short of the target
    push_sample(64'd100_001_010);             // just past target, current nearer
    push_sample(64'd150_001_000);
    push_sample(64'd260_001_000);             // previous nearer
    push_sample(64'd340_001_000);             // equal distance, current wins
    push_sample(64'd600_001_000);             // overshoot by two intervals
    push_sample(64'd605_001_000);
    push_sample(64'd790_001_000);             // current nearer
    push_sample(64'd820_001_000);             // previous is the last pick: none
    push_sample(TIME_MAX - 64'd10);           // target saturates
    push_sample(TIME_MAX);
    push_clear(64'hFFFF_FFFF_FFFF_FFFF);
    push_sample(64'd5);
    push_clear(64'd0);
    push_sample(TIME_MAX);                    // first sample at the top
    push_sample(TIME_MAX - 64'd1);
    push_sample(64'd1);

    run_phase(63'd1, 2, 1, 1'b0, 90);
    run_phase(63'd1000, 0, 0, 1'b0, 90);                    // no idling at all
    run_phase(63'd0, 3, 2, 1'b0, 40);                       // selects nothing
    run_phase(63'h7FFF_FFFF_FFFF_FFFF, 5, 1, 1'b0, 60);     // largest interval
    run_phase(63'($urandom_range(1 << 20, 1)), 0, 0, 1'b1, 80); // back-pressure
    run_phase(63'({$urandom, $urandom} >> 24), 8, 2, 1'b0, 90);
    run_phase(63'd7, 1, 1, 1'b0, 90);
    run_phase(INTERVAL_RESET, 4, 2, 1'b0, 120);
    run_phase(63'({$urandom, $urandom} >> 2), 2, 1, 1'b0, 60);

    settle();
    if (fail_count == 0 && decision_q.size() == 0) begin
      $display("timestamp_rate_decimator_unit test passed");
    end else begin
      $display("timestamp_rate_decimator_unit test failed");
    end
    $finish;
  end

endmodule
